>>> src/swmm_pkg.sv
// Shared types and constants for the sliding window min/max core.
package swmm_pkg;

  localparam int CFG_W = 9;
  localparam logic [CFG_W-1:0] WIN_LEN_RESET = 9'd256;
  localparam int SAMPLE_W = 16;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } swmm_state_t;

  typedef struct packed {
    logic take;
    logic scan;
    logic emit;
  } swmm_cmd_t;

  typedef struct packed {
    logic need_scan;
    logic scan_done;
    logic out_free;
  } swmm_sts_t;

endpackage

>>> src/swmm_in_if.sv
// Sample input channel: valid/ready handshake with one sample per beat.
interface swmm_in_if;
  swmm_pkg::sample_t sample;
  logic              valid;
  logic              ready;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

>>> src/swmm_out_if.sv
// Result channel: valid/ready handshake carrying window max, min and change flag.
interface swmm_out_if;
  logic              range_changed;
  swmm_pkg::sample_t window_max;
  swmm_pkg::sample_t window_min;
  logic              valid;
  logic              ready;

  modport source (output valid, output range_changed, output window_max,
                  output window_min, input ready);
  modport sink (input valid, input range_changed, input window_max,
                input window_min, output ready);
endinterface

>>> src/swmm_ctrl.sv
// Controller state machine: sequences sample intake, rescan and result beat.
module swmm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  swmm_pkg::swmm_sts_t sts,
  output swmm_pkg::swmm_cmd_t cmd
);
  import swmm_pkg::*;

  swmm_state_t state_r;
  swmm_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take  = 1'b1;
          state_nxt = sts.need_scan ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (sts.scan_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

>>> src/swmm_datapath.sv
// Datapath: sample ring store, extremes with ages, rescan engine, output register.
module swmm_datapath #(
  parameter int MAX_WINDOW = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  swmm_pkg::swmm_cmd_t        cmd,
  output swmm_pkg::swmm_sts_t        sts,
  input  swmm_pkg::sample_t          in_sample,
  input  logic                       cfg_we,
  input  logic [swmm_pkg::CFG_W-1:0] cfg_wdata,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic                       out_range_changed,
  output swmm_pkg::sample_t          out_window_max,
  output swmm_pkg::sample_t          out_window_min
);
  import swmm_pkg::*;

  localparam int AW = $clog2(MAX_WINDOW);
  localparam int CW = $clog2(MAX_WINDOW + 1);
  localparam int LW = (CW > CFG_W) ? CW : CFG_W;
  localparam logic [AW-1:0] LAST_POS = AW'(MAX_WINDOW - 1);

  sample_t mem [MAX_WINDOW];

  logic [CFG_W-1:0] win_len_r;
  logic [AW-1:0]    wp_r;
  logic [CW-1:0]    fill_r;
  sample_t          cur_max_r;
  sample_t          cur_min_r;
  logic [CW-1:0]    max_age_r;
  logic [CW-1:0]    min_age_r;
  logic             changed_r;

  logic [AW-1:0]    iss_ptr_r;
  logic [CW-1:0]    iss_age_r;
  logic [CW-1:0]    iss_cnt_r;
  logic             rd_vld_r;
  logic [CW-1:0]    rd_age_r;
  sample_t          rd_data_r;

  logic             out_valid_r;
  logic             out_changed_r;
  sample_t          out_max_r;
  sample_t          out_min_r;

  logic [LW-1:0]    wl_ext;
  logic [LW-1:0]    w_full;
  logic [CW-1:0]    win;
  logic             was_empty;
  logic [CW:0]      fill_inc;
  logic [CW-1:0]    fill_nxt;
  logic             max_up;
  logic             min_dn;
  logic [CW-1:0]    max_age_nxt;
  logic [CW-1:0]    min_age_nxt;
  logic             need_scan;
  logic             changed_nxt;
  logic [AW-1:0]    wp_nxt;
  logic [AW-1:0]    wp_prev;
  logic [AW-1:0]    iss_ptr_nxt;

  assign wl_ext = LW'(win_len_r);

  always_comb begin
    if (wl_ext < LW'(2)) begin
      w_full = LW'(2);
    end else if (wl_ext > LW'(MAX_WINDOW)) begin
      w_full = LW'(MAX_WINDOW);
    end else begin
      w_full = wl_ext;
    end
  end

  assign win         = w_full[CW-1:0];
  assign was_empty   = (fill_r == '0);
  assign fill_inc    = {1'b0, fill_r} + (CW+1)'(1);
  assign fill_nxt    = (fill_inc > {1'b0, win}) ? win : fill_inc[CW-1:0];
  assign max_up      = in_sample > cur_max_r;
  assign min_dn      = in_sample < cur_min_r;
  assign max_age_nxt = max_up ? '0 : max_age_r + CW'(1);
  assign min_age_nxt = min_dn ? '0 : min_age_r + CW'(1);
  assign need_scan   = !was_empty && ((max_age_nxt >= win) || (min_age_nxt >= win));
  assign changed_nxt = was_empty || max_up || min_dn || need_scan;
  assign wp_nxt      = (wp_r == LAST_POS) ? '0 : wp_r + AW'(1);
  assign wp_prev     = (wp_r == '0) ? LAST_POS : wp_r - AW'(1);
  assign iss_ptr_nxt = (iss_ptr_r == '0) ? LAST_POS : iss_ptr_r - AW'(1);

  assign sts.need_scan = need_scan;
  assign sts.scan_done = (iss_cnt_r == '0) && !rd_vld_r;
  assign sts.out_free  = !out_valid_r || out_ready;

  // Ring store: write on intake, one registered read per scan cycle while reads remain.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      mem[wp_r] <= in_sample;
    end
    if (cmd.scan && (iss_cnt_r != '0)) begin
      rd_data_r <= mem[iss_ptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_len_r   <= WIN_LEN_RESET;
      wp_r        <= '0;
      fill_r      <= '0;
      cur_max_r   <= '0;
      cur_min_r   <= '0;
      max_age_r   <= '0;
      min_age_r   <= '0;
      iss_cnt_r   <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        win_len_r <= cfg_wdata;
      end
      if (cmd.take) begin
        wp_r   <= wp_nxt;
        fill_r <= fill_nxt;
        if (was_empty || need_scan) begin
          cur_max_r <= in_sample;
          cur_min_r <= in_sample;
          max_age_r <= '0;
          min_age_r <= '0;
        end else begin
          if (max_up) begin
            cur_max_r <= in_sample;
          end
          if (min_dn) begin
            cur_min_r <= in_sample;
          end
          max_age_r <= max_age_nxt;
          min_age_r <= min_age_nxt;
        end
        if (need_scan) begin
          iss_cnt_r <= fill_nxt - CW'(1);
        end
      end
      if (cmd.scan) begin
        if (iss_cnt_r != '0) begin
          iss_cnt_r <= iss_cnt_r - CW'(1);
          rd_vld_r  <= 1'b1;
        end else begin
          rd_vld_r <= 1'b0;
        end
        if (rd_vld_r) begin
          if (rd_data_r > cur_max_r) begin
            cur_max_r <= rd_data_r;
            max_age_r <= rd_age_r;
          end
          if (rd_data_r < cur_min_r) begin
            cur_min_r <= rd_data_r;
            min_age_r <= rd_age_r;
          end
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      changed_r <= changed_nxt;
      iss_ptr_r <= wp_prev;
      iss_age_r <= CW'(1);
    end
    if (cmd.scan && (iss_cnt_r != '0)) begin
      iss_ptr_r <= iss_ptr_nxt;
      iss_age_r <= iss_age_r + CW'(1);
      rd_age_r  <= iss_age_r;
    end
    if (cmd.emit) begin
      out_changed_r <= changed_r;
      out_max_r     <= cur_max_r;
      out_min_r     <= cur_min_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_range_changed = out_changed_r;
  assign out_window_max    = out_max_r;
  assign out_window_min    = out_min_r;

  a_max_ge_min: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r != '0) |-> (cur_max_r >= cur_min_r))
    else $error("window max below window min");

  a_scan_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    ((iss_cnt_r != '0) || rd_vld_r) |-> (!cmd.take && !cmd.emit))
    else $error("intake or result beat during rescan");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> (!out_valid_r || out_ready))
    else $error("result beat overwrites pending result");

  a_fill_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |=> (fill_r != '0))
    else $error("window empty after sample intake");

endmodule

>>> src/sliding_window_min_max_core.sv
// Sliding window min/max core top level.
// Without a rescan, an input beat leads to the result state, which loads the
// output register once the output is free. A rescan first reads the older
// samples, one ring store read per cycle. Intake waits for the output load.
// Reset: synchronous active-low rst_n empties the window, window_length = 256.
module sliding_window_min_max_core #(
  parameter int MAX_WINDOW = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  swmm_in_if.sink                    in_ch,
  swmm_out_if.source                 out_ch,
  input  logic                       cfg_we,
  input  logic [swmm_pkg::CFG_W-1:0] cfg_wdata
);
  import swmm_pkg::*;

  swmm_cmd_t cmd;
  swmm_sts_t sts;

  swmm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  swmm_datapath #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_datapath (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .sts               (sts),
    .in_sample         (in_ch.sample),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_range_changed (out_ch.range_changed),
    .out_window_max    (out_ch.window_max),
    .out_window_min    (out_ch.window_min)
  );

endmodule

>>> dv/sliding_window_min_max_core_test.sv
// Testbench for the sliding window min/max core, checked against a cycle-free window predictor.
`timescale 1ns / 100ps

module sliding_window_min_max_core_test;
  import swmm_pkg::*;

  localparam int MAX_WIN = 256;
  localparam int WIN_FLOOR = 2;
  localparam int RANDOM_ITEMS = 1800;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int MAX_PRINTED = 40;

  typedef enum int {
    GEN_UNIFORM,
    GEN_NARROW,
    GEN_FALL,
    GEN_RISE,
    GEN_EDGES,
    GEN_WALK
  } sample_gen_e;

  typedef struct {
    logic    chg;
    sample_t hi;
    sample_t lo;
  } window_result_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_W-1:0] cfg_wdata;

  swmm_in_if  in_ch ();
  swmm_out_if out_ch ();

  sliding_window_min_max_core #(
    .MAX_WINDOW(MAX_WIN)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  sample_t        pending_samples[$];
  window_result_t expected_results[$];

  sample_t        win_ring[MAX_WIN];
  logic [7:0]     win_wpos;
  int             win_fill;
  sample_t        win_hi;
  sample_t        win_lo;
  int             hi_age;
  int             lo_age;
  logic [CFG_W-1:0] win_len;

  int mismatches;
  int results_seen;
  int samples_taken;
  int rescans_seen;
  int changes_seen;
  int settings_used;
  int cycle_count;

  logic steady;
  logic hold_go;
  int   hold_left;
  int   burst_left;
  int   gap_left;
  logic [4:0] rx_cnt;
  int   stall_len;

  sample_t gen_base;
  int      gen_step;

  function automatic void predict_window(sample_t s);
    int w;
    int k;
    logic [7:0] pos;
    logic chg;
    logic was_empty;
    w = (win_len < WIN_FLOOR) ? WIN_FLOOR : (win_len > MAX_WIN) ? MAX_WIN : int'(win_len);
    chg = 1'b0;
    was_empty = (win_fill == 0);
    win_ring[win_wpos] = s;
    win_wpos = win_wpos + 8'd1;
    win_fill = (win_fill + 1 > w) ? w : win_fill + 1;
    if (was_empty) begin
      win_hi = s;
      win_lo = s;
      hi_age = 0;
      lo_age = 0;
      chg = 1'b1;
    end else begin
      if (s > win_hi) begin
        win_hi = s;
        hi_age = 0;
        chg = 1'b1;
      end else begin
        hi_age++;
      end
      if (s < win_lo) begin
        win_lo = s;
        lo_age = 0;
        chg = 1'b1;
      end else begin
        lo_age++;
      end
      if (hi_age >= w || lo_age >= w) begin
        // walk newest to oldest, keep the newer sample on ties
        pos = win_wpos - 8'd1;
        win_hi = win_ring[pos];
        win_lo = win_ring[pos];
        hi_age = 0;
        lo_age = 0;
        for (k = 1; k < win_fill; k++) begin
          pos = pos - 8'd1;
          if (win_ring[pos] > win_hi) begin
            win_hi = win_ring[pos];
            hi_age = k;
          end
          if (win_ring[pos] < win_lo) begin
            win_lo = win_ring[pos];
            lo_age = k;
          end
        end
        chg = 1'b1;
        rescans_seen++;
      end
    end
    if (chg) changes_seen++;
    samples_taken++;
    expected_results.push_back('{chg, win_hi, win_lo});
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatches < MAX_PRINTED)
      $display("MISMATCH beat %0d %s: got %0d, expected %0d", results_seen, what, got, want);
    mismatches++;
  endtask

  function automatic sample_t next_sample(sample_gen_e g);
    sample_t s;
    case (g)
      GEN_UNIFORM: s = sample_t'($urandom);
      GEN_NARROW: s = gen_base + sample_t'($urandom_range(0, 3));
      GEN_FALL: begin
        gen_base = gen_base - sample_t'($urandom_range(0, gen_step));
        s = gen_base;
      end
      GEN_RISE: begin
        gen_base = gen_base + sample_t'($urandom_range(0, gen_step));
        s = gen_base;
      end
      GEN_EDGES: begin
        case ($urandom_range(0, 4))
          0: s = 16'sh7FFF;
          1: s = 16'sh8000;
          2: s = 16'sh0000;
          3: s = -16'sd1;
          default: s = 16'sd1;
        endcase
      end
      default: begin
        gen_base = sample_t'(int'(gen_base) + int'($urandom_range(0, 2 * gen_step)) - gen_step);
        s = gen_base;
      end
    endcase
    return s;
  endfunction

  // sender: bursts and gaps, hold the beat while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.sample <= '0;
      burst_left <= 4;
      gap_left <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) predict_window(in_ch.sample);
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (gap_left != 0 && !steady) begin
          in_ch.valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (pending_samples.size() != 0) begin
          in_ch.valid <= 1'b1;
          in_ch.sample <= pending_samples.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (hold_go) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // receiver: stall window rerolled each time the 5-bit rx_cnt wraps
  always @(posedge clk) begin
    rx_cnt <= rx_cnt + 5'd1;
    if (rx_cnt == 5'd0) stall_len <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    out_ch.ready <= (hold_left == 0) && (steady || (int'(rx_cnt) >= stall_len));
  end

  always @(posedge clk) begin : result_check
    window_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected beat, max", int'(out_ch.window_max), 0);
      end else begin
        want = expected_results.pop_front();
        if (out_ch.range_changed !== want.chg)
          report_mismatch("range_changed", int'(out_ch.range_changed), int'(want.chg));
        if (out_ch.window_max !== want.hi)
          report_mismatch("window_max", int'(out_ch.window_max), int'(want.hi));
        if (out_ch.window_min !== want.lo)
          report_mismatch("window_min", int'(out_ch.window_min), int'(want.lo));
      end
      results_seen++;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_count,
               expected_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic set_window(logic [CFG_W-1:0] len);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_we <= 1'b0;
    win_len = len;
    settings_used++;
  endtask

  task automatic drain();
    while (pending_samples.size() != 0 || in_ch.valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int random_sent;
    int phase;
    int n;
    int pick;
    logic [CFG_W-1:0] len;
    sample_gen_e mode;

    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    out_ch.ready = 1'b0;
    steady = 1'b0;
    hold_go = 1'b0;
    hold_left = 0;
    rx_cnt = '0;
    stall_len = 0;
    cycle_count = 0;
    mismatches = 0;
    results_seen = 0;
    samples_taken = 0;
    rescans_seen = 0;
    changes_seen = 0;
    settings_used = 0;
    win_wpos = '0;
    win_fill = 0;
    win_hi = '0;
    win_lo = '0;
    hi_age = 0;
    lo_age = 0;
    win_len = WIN_LEN_RESET;
    gen_base = '0;
    gen_step = 1;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // first sample after reset, field extremes and ties at the reset window
    pending_samples = '{16'sd0, 16'sh7FFF, 16'sh8000, -16'sd1, 16'sd1, 16'sd16, -16'sd16,
                        16'sh7FFF, 16'sh8000, 16'sh5555, 16'shAAAA};
    drain();
    // shrink below the floor while running: rescan at the clamped window
    set_window(9'd0);
    pending_samples = '{16'sd5, 16'sd5, 16'sd4, 16'sd6, 16'sd3, 16'sd3};
    drain();
    set_window(9'd1);
    pending_samples = '{16'sh8000, 16'sh7FFF, 16'sh7FFF};
    drain();
    // grow past the ceiling
    set_window(9'd511);
    pending_samples = '{-16'sd2, 16'sd2, -16'sd2, 16'sd0};
    drain();

    random_sent = 0;
    phase = 0;
    while (random_sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      case (pick)
        0: len = CFG_W'($urandom_range(0, 1));
        1: len = 9'd2;
        2: len = CFG_W'($urandom_range(3, 8));
        3, 4: len = CFG_W'($urandom_range(9, 40));
        5: len = CFG_W'($urandom_range(41, 128));
        6: len = CFG_W'($urandom_range(129, 255));
        7: len = 9'd256;
        8: len = CFG_W'($urandom_range(257, 511));
        default: len = CFG_W'($urandom_range(0, 511));
      endcase
      mode = sample_gen_e'($urandom_range(0, 5));
      n = $urandom_range(30, 120);
      if (phase == 0) begin
        len = 9'd256;
        mode = GEN_UNIFORM;
        n = 400;
      end else if (phase == 1) begin
        len = 9'd2;
        mode = GEN_WALK;
      end
      set_window(len);
      steady <= (phase != 0) && ($urandom_range(0, 3) == 0);
      gen_base = sample_t'($urandom);
      gen_step = $urandom_range(1, 64);
      repeat (n) pending_samples.push_back(next_sample(mode));
      if (phase == 0) begin
        // block the result side long enough to back up the input
        repeat (20) @(posedge clk);
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
      end
      random_sent += n;
      phase++;
      drain();
    end

    $display("Covered %0d samples across %0d window settings (floor, ceiling and beyond).",
             samples_taken, settings_used);
    $display("Predicted %0d rescans and %0d range changes; checked %0d result beats.",
             rescans_seen, changes_seen, results_seen);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
